// ----- hw/rtl/cva_pkg.sv -----
// Shared types and constants for the Cramer's V association block.
// No dependencies; imported by every module of the block.
package cva_pkg;

  localparam int CATEGORIES = 16;
  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int GUARD      = 32;

  localparam int CODE_W = 4;
  localparam int OUT_W  = 17;
  localparam int IDX_W  = $clog2(CATEGORIES);
  localparam int CELLS  = CATEGORIES * CATEGORIES;
  localparam int CELL_W = $clog2(CELLS);
  localparam int LVL_W  = $clog2(CATEGORIES + 1);
  localparam int SUM_W  = GUARD + LVL_W + 1;
  localparam int DEN_W  = (2 * COUNT_BITS > GUARD + LVL_W) ? 2 * COUNT_BITS : GUARD + LVL_W;
  localparam int DIV_A  = 2 * COUNT_BITS + GUARD;
  localparam int DIV_B  = SUM_W + 2 * FRAC_BITS;
  localparam int DIV_C  = 2 * LVL_W + GUARD;
  localparam int DIV_AB = (DIV_A > DIV_B) ? DIV_A : DIV_B;
  localparam int DIV_W  = (DIV_AB > DIV_C) ? DIV_AB : DIV_C;
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int SQ_W   = 2 * FRAC_BITS;
  localparam int Q_DEPTH = 4;
  localparam int QP_W    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [CODE_W-1:0] x_code;
    logic [CODE_W-1:0] y_code;
    logic              last_pair;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] cramers_v;
    logic             count_overflow;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] x;
    logic [IDX_W-1:0] y;
    logic             counted;
    logic             last;
  } q_entry_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hw/rtl/cva_front.sv -----
// Input side: accepts pairs, marks in-range codes and queues them.
// Depends on cva_pkg.
module cva_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cva_pkg::in_item_t in_data,
  output logic              q_valid,
  output cva_pkg::q_entry_t q_entry,
  input  logic              q_pop
);
  import cva_pkg::*;

  q_entry_t          fifo_r [Q_DEPTH];
  logic [QP_W-1:0]   wp_r, rp_r;
  logic [QP_W:0]     cnt_r;
  logic              push;
  logic              pop;
  q_entry_t          ent;

  assign in_ready = (cnt_r != (QP_W+1)'(Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_entry  = fifo_r[rp_r];

  always_comb begin
    ent.x       = IDX_W'(in_data.x_code);
    ent.y       = IDX_W'(in_data.y_code);
    ent.counted = ({28'd0, in_data.x_code} < 32'(CATEGORIES)) &&
                  ({28'd0, in_data.y_code} < 32'(CATEGORIES));
    ent.last    = in_data.last_pair;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (!push && pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ----- hw/rtl/cva_divider.sv -----
// Serial restoring divider, one quotient bit per cycle.
// Depends on cva_pkg.
module cva_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  cva_pkg::div_req_t req,
  output cva_pkg::div_rsp_t rsp
);
  import cva_pkg::*;

  logic [DIV_W-1:0]  quo_r;
  logic [DEN_W:0]    rem_r;
  logic [DEN_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DEN_W:0]    trial;
  logic              ge;

  assign trial = {rem_r[DEN_W-1:0], quo_r[DIV_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? (trial - {1'b0, dvs_r}) : trial;
    end
  end

endmodule

// ----- hw/rtl/cva_back.sv -----
// Back end: counts queued pairs into the tables, then walks them to form V.
// Depends on cva_pkg and cva_divider.
module cva_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               bias_correct,
  input  logic               q_valid,
  input  cva_pkg::q_entry_t  q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output cva_pkg::out_item_t out_data
);
  import cva_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'h0001,
    ST_UPD   = 15'h0002,
    ST_START = 15'h0004,
    ST_CELL  = 15'h0008,
    ST_CDAT  = 15'h0010,
    ST_CMUL  = 15'h0020,
    ST_CDIV  = 15'h0040,
    ST_PHI   = 15'h0080,
    ST_B1    = 15'h0100,
    ST_B2    = 15'h0200,
    ST_B3    = 15'h0400,
    ST_CHK   = 15'h0800,
    ST_FDIV  = 15'h1000,
    ST_SQRT  = 15'h2000,
    ST_OUT   = 15'h4000
  } state_t;

  localparam logic [SUM_W-1:0] ONE_G = SUM_W'(1) << GUARD;
  localparam logic [OUT_W-1:0] ONE_V = OUT_W'(1) << FRAC_BITS;

  state_t                state_r;
  logic [COUNT_BITS-1:0] mem [CELLS];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic [CELL_W-1:0]     rd_addr_r;
  logic [CELL_W-1:0]     rd_addr;
  logic [CELLS-1:0]      jv_r;
  logic                  mem_we;
  logic [COUNT_BITS-1:0] o_val;

  logic [COUNT_BITS-1:0] row_r [CATEGORIES];
  logic [COUNT_BITS-1:0] col_r [CATEGORIES];
  logic [COUNT_BITS-1:0] total_r;
  logic                  ovf_r;
  q_entry_t              cur_r;

  logic [IDX_W-1:0]      i_r, j_r;
  logic [SUM_W-1:0]      s_r;
  logic [2*COUNT_BITS-1:0] sq_r, rc_r;
  logic [DIV_W-1:0]      corr_r, tr_r;
  logic [SUM_W-1:0]      num_r;
  logic [DEN_W-1:0]      den_r;
  logic [LVL_W-1:0]      r_r, c_r;
  logic [SQ_W-1:0]       sqv_r, res_r, bit_r;
  logic [OUT_W-1:0]      res_v_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic [CATEGORIES-1:0] row_nz, col_nz;
  logic [LVL_W-1:0]      r_cnt, c_cnt;
  logic                  last_cell;
  logic [SQ_W-1:0]       rb;
  logic [SQ_W-1:0]       res_nxt;
  logic [DIV_W-1:0]      dr, dc, dr_c, dc_c, phi_w;
  logic [SUM_W-1:0]      num_c;
  logic [DEN_W-1:0]      den_c;
  logic                  load_out;
  div_req_t              dreq;
  div_rsp_t              drsp;

  cva_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  always_comb begin
    for (int k = 0; k < CATEGORIES; k++) begin
      row_nz[k] = (row_r[k] != '0);
      col_nz[k] = (col_r[k] != '0);
    end
  end
  assign r_cnt = LVL_W'($countones(row_nz));
  assign c_cnt = LVL_W'($countones(col_nz));

  assign last_cell = (i_r == IDX_W'(CATEGORIES - 1)) && (j_r == IDX_W'(CATEGORIES - 1));
  assign o_val     = jv_r[rd_addr_r] ? rd_data_r : '0;
  assign q_pop     = (state_r == ST_IDLE);
  assign mem_we    = (state_r == ST_UPD);

  always_comb begin
    if (state_r == ST_IDLE)
      rd_addr = CELL_W'(q_entry.x) * CELL_W'(CATEGORIES) + CELL_W'(q_entry.y);
    else
      rd_addr = CELL_W'(i_r) * CELL_W'(CATEGORIES) + CELL_W'(j_r);
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (mem_we) begin
      mem[rd_addr_r] <= o_val + 1'b1;
    end
  end

  assign rb      = res_r + bit_r;
  assign res_nxt = (sqv_r >= rb) ? ((res_r >> 1) + bit_r) : (res_r >> 1);

  always_comb begin
    dr    = DIV_W'(r_r - 1'b1) << GUARD;
    dc    = DIV_W'(c_r - 1'b1) << GUARD;
    dr_c  = (dr > tr_r) ? dr - tr_r : '0;
    dc_c  = (dc > drsp.quotient) ? dc - drsp.quotient : '0;
    den_c = (dr_c < dc_c) ? DEN_W'(dr_c) : DEN_W'(dc_c);
    phi_w = DIV_W'(s_r);
    num_c = (phi_w > corr_r) ? SUM_W'(phi_w - corr_r) : '0;
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = DIV_W'(sq_r) << GUARD;
    dreq.divisor  = DEN_W'(rc_r);
    case (state_r)
      ST_CMUL: begin
        dreq.start = 1'b1;
      end
      ST_PHI: begin
        dreq.start    = bias_correct;
        dreq.dividend = DIV_W'((2*LVL_W)'(r_r - 1'b1) * (2*LVL_W)'(c_r - 1'b1)) << GUARD;
        dreq.divisor  = DEN_W'(total_r - 1'b1);
      end
      ST_B1: begin
        dreq.start    = drsp.done;
        dreq.dividend = DIV_W'((2*LVL_W)'(r_r - 1'b1) * (2*LVL_W)'(r_r - 1'b1)) << GUARD;
        dreq.divisor  = DEN_W'(total_r - 1'b1);
      end
      ST_B2: begin
        dreq.start    = drsp.done;
        dreq.dividend = DIV_W'((2*LVL_W)'(c_r - 1'b1) * (2*LVL_W)'(c_r - 1'b1)) << GUARD;
        dreq.divisor  = DEN_W'(total_r - 1'b1);
      end
      ST_CHK: begin
        dreq.start    = (num_r != '0) && (DIV_W'(num_r) < DIV_W'(den_r));
        dreq.dividend = DIV_W'(num_r) << SQ_W;
        dreq.divisor  = den_r;
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase
  end

  assign load_out  = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.cramers_v      <= res_v_r;
      out_r.count_overflow <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      jv_r        <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < CATEGORIES; k++) begin
        row_r[k] <= '0;
        col_r[k] <= '0;
      end
    end else begin
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            cur_r     <= q_entry;
            rd_addr_r <= rd_addr;
            if (q_entry.counted && (total_r != '1)) begin
              state_r <= ST_UPD;
            end else begin
              if (q_entry.counted) ovf_r <= 1'b1;
              if (q_entry.last) state_r <= ST_START;
            end
          end
        end
        ST_UPD: begin
          jv_r[rd_addr_r] <= 1'b1;
          total_r         <= total_r + 1'b1;
          row_r[cur_r.x]  <= row_r[cur_r.x] + 1'b1;
          col_r[cur_r.y]  <= col_r[cur_r.y] + 1'b1;
          state_r         <= cur_r.last ? ST_START : ST_IDLE;
        end
        ST_START: begin
          r_r <= r_cnt;
          c_r <= c_cnt;
          i_r <= '0;
          j_r <= '0;
          s_r <= '0;
          if (r_cnt < LVL_W'(2) || c_cnt < LVL_W'(2)) begin
            res_v_r <= ONE_V;
            state_r <= ST_OUT;
          end else begin
            state_r <= ST_CELL;
          end
        end
        ST_CELL: begin
          rd_addr_r <= rd_addr;
          if (row_nz[i_r] && col_nz[j_r]) begin
            state_r <= ST_CDAT;
          end else if (last_cell) begin
            state_r <= ST_PHI;
          end else begin
            j_r <= j_r + 1'b1;
            if (j_r == IDX_W'(CATEGORIES - 1)) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
            end
          end
        end
        ST_CDAT: begin
          sq_r <= (2*COUNT_BITS)'(o_val) * (2*COUNT_BITS)'(o_val);
          rc_r <= (2*COUNT_BITS)'(row_r[i_r]) * (2*COUNT_BITS)'(col_r[j_r]);
          if (o_val != '0) begin
            state_r <= ST_CMUL;
          end else if (last_cell) begin
            state_r <= ST_PHI;
          end else begin
            state_r <= ST_CELL;
            j_r     <= j_r + 1'b1;
            if (j_r == IDX_W'(CATEGORIES - 1)) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
            end
          end
        end
        ST_CMUL: begin
          state_r <= ST_CDIV;
        end
        ST_CDIV: begin
          if (drsp.done) begin
            s_r <= s_r + SUM_W'(drsp.quotient);
            if (last_cell) begin
              state_r <= ST_PHI;
            end else begin
              state_r <= ST_CELL;
              j_r     <= j_r + 1'b1;
              if (j_r == IDX_W'(CATEGORIES - 1)) begin
                j_r <= '0;
                i_r <= i_r + 1'b1;
              end
            end
          end
        end
        ST_PHI: begin
          s_r <= (s_r > ONE_G) ? s_r - ONE_G : '0;
          if (bias_correct) begin
            state_r <= ST_B1;
          end else begin
            num_r   <= (s_r > ONE_G) ? s_r - ONE_G : '0;
            den_r   <= (r_r < c_r) ? (DEN_W'(r_r - 1'b1) << GUARD)
                                   : (DEN_W'(c_r - 1'b1) << GUARD);
            state_r <= ST_CHK;
          end
        end
        ST_B1: begin
          if (drsp.done) begin
            corr_r  <= drsp.quotient;
            state_r <= ST_B2;
          end
        end
        ST_B2: begin
          if (drsp.done) begin
            tr_r    <= drsp.quotient;
            state_r <= ST_B3;
          end
        end
        ST_B3: begin
          if (drsp.done) begin
            num_r   <= num_c;
            den_r   <= den_c;
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (num_r == '0) begin
            res_v_r <= '0;
            state_r <= ST_OUT;
          end else if (DIV_W'(num_r) >= DIV_W'(den_r)) begin
            res_v_r <= ONE_V;
            state_r <= ST_OUT;
          end else begin
            state_r <= ST_FDIV;
          end
        end
        ST_FDIV: begin
          if (drsp.done) begin
            sqv_r   <= drsp.quotient[SQ_W-1:0];
            res_r   <= '0;
            bit_r   <= SQ_W'(1) << (SQ_W - 2);
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqv_r >= rb) sqv_r <= sqv_r - rb;
          res_r <= res_nxt;
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            res_v_r <= OUT_W'(res_nxt);
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (load_out) begin
            jv_r    <= '0;
            total_r <= '0;
            ovf_r   <= 1'b0;
            for (int k = 0; k < CATEGORIES; k++) begin
              row_r[k] <= '0;
              col_r[k] <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/cramers_v_association.sv -----
// Cramer's V association: pairs of category codes are queued (four deep) and
// counted into a joint table and two marginal tables, one state reading the
// joint table memory and another writing it back. The pair marked last starts
// the result: the walk visits every table cell with a serial divide for each
// occupied cell, then up to four more such divides and one square-root step per
// output fraction bit; the tables clear as the result is loaded for output.
// Pairs keep being queued, up to the queue depth, while a result is formed.
// Depends on cva_pkg, cva_front, cva_back.
module cramers_v_association (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cva_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cva_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import cva_pkg::*;

  logic     bias_r;
  logic     q_valid, q_pop;
  q_entry_t q_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= 1'b0;
    end else if (cfg_we) begin
      bias_r <= cfg_wdata;
    end
  end

  cva_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  cva_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .bias_correct(bias_r),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
